[src/lrc_pkg.sv]
// lru replacement cache package: sizes, widths and the result record
// shared by the engine and the top level; no dependencies
package lrc_pkg;

   localparam int unsigned ENTRIES   = 8;
   localparam int unsigned KEY_WIDTH = 8;
   localparam int unsigned IDX_W     = $clog2(ENTRIES);
   localparam int unsigned RANK_W    = $clog2(ENTRIES);
   localparam int unsigned LIMIT_W   = RANK_W + 1;
   localparam int unsigned WORD_W    = KEY_WIDTH + RANK_W;
   localparam int unsigned CNT_W     = 32;

   localparam logic [IDX_W:0]     SWEEP_END = (IDX_W + 1)'(ENTRIES);
   localparam logic [LIMIT_W-1:0] LIMIT_ALL = LIMIT_W'(ENTRIES);
   localparam logic [CNT_W-1:0]   CNT_MAX   = '1;

   typedef struct packed {
      logic                 hit;
      logic [IDX_W-1:0]     slot;
      logic                 evicted;
      logic [KEY_WIDTH-1:0] evicted_key;
      logic [CNT_W-1:0]     hit_count;
      logic [CNT_W-1:0]     miss_count;
   } result_type;

endpackage

[src/lru_replacement_cache_top.sv]
// lru replacement cache top level: slot memory, engine and result register
// depends on lrc_pkg, lrc_ram, lrc_engine
//
//  channel | ports                                   | direction
//  req     | req_valid, req_stall, req_key           | access key in
//  rsp     | rsp_valid, rsp_stall, rsp_hit .. counts | one result beat per access
//
// one access runs the scan sweep and then the rank update sweep, both
// through the one read port of the slot memory
// reset clears the valid bits and totals; no clearing pass
// a new beat is taken while the previous result waits in the output register
// a stalled result holds the engine only at the hand-over of the next result
module lru_replacement_cache_top (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  logic [7:0]   req_key,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output logic         rsp_hit,
   output logic [2:0]   rsp_slot,
   output logic         rsp_evicted,
   output logic [7:0]   rsp_evicted_key,
   output logic [31:0]  rsp_hit_count,
   output logic [31:0]  rsp_miss_count
);

   logic                          busy;
   logic                          rd_en;
   logic [lrc_pkg::IDX_W-1:0]     rd_addr;
   logic [lrc_pkg::WORD_W-1:0]    rd_data;
   logic                          wr_en;
   logic [lrc_pkg::IDX_W-1:0]     wr_addr;
   logic [lrc_pkg::WORD_W-1:0]    wr_data;
   logic                          res_vld;
   lrc_pkg::result_type           res;
   logic                          res_take;

   logic                          rsp_valid_ff, rsp_valid_in;
   lrc_pkg::result_type           rsp_ff, rsp_in;

   lrc_ram #(
      .WIDTH (lrc_pkg::WORD_W),
      .DEPTH (lrc_pkg::ENTRIES)
   ) u_slot_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   lrc_engine u_engine (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_key   (lrc_pkg::KEY_WIDTH'(req_key)),
      .busy      (busy),
      .rd_en     (rd_en),
      .rd_addr   (rd_addr),
      .rd_data   (rd_data),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data),
      .res_vld   (res_vld),
      .res       (res),
      .res_take  (res_take)
   );

   assign req_stall = busy;
   assign res_take  = res_vld && (!rsp_valid_ff || !rsp_stall);

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (res_take) begin
         rsp_valid_in = 1'b1;
         rsp_in       = res;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_ff <= rsp_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_hit         = rsp_ff.hit;
   assign rsp_slot        = 3'(rsp_ff.slot);
   assign rsp_evicted     = rsp_ff.evicted;
   assign rsp_evicted_key = 8'(rsp_ff.evicted_key);
   assign rsp_hit_count   = rsp_ff.hit_count;
   assign rsp_miss_count  = rsp_ff.miss_count;

endmodule

[src/lrc_ram.sv]
// generic simple dual-port ram, one write and one registered read port
// no dependencies
module lrc_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 8
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[src/lrc_engine.sv]
// lookup and replacement engine: scan sweep and rank update sweep over the
// slot memory, valid bits and hit/miss totals; depends on lrc_pkg
module lrc_engine (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   input  logic [lrc_pkg::KEY_WIDTH-1:0]   req_key,
   output logic                            busy,
   output logic                            rd_en,
   output logic [lrc_pkg::IDX_W-1:0]       rd_addr,
   input  logic [lrc_pkg::WORD_W-1:0]      rd_data,
   output logic                            wr_en,
   output logic [lrc_pkg::IDX_W-1:0]       wr_addr,
   output logic [lrc_pkg::WORD_W-1:0]      wr_data,
   output logic                            res_vld,
   output lrc_pkg::result_type             res,
   input  logic                            res_take
);

   typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_UPDATE, ST_DONE} state_type;

   state_type                       state_ff, state_in;
   logic [lrc_pkg::KEY_WIDTH-1:0]   key_ff, key_in;
   logic [lrc_pkg::IDX_W:0]         addr_ff, addr_in;
   logic                            pipe_vld_ff, pipe_vld_in;
   logic [lrc_pkg::IDX_W-1:0]       pipe_idx_ff, pipe_idx_in;
   logic                            hit_ff, hit_in;
   logic [lrc_pkg::IDX_W-1:0]       hit_slot_ff, hit_slot_in;
   logic [lrc_pkg::RANK_W-1:0]      hit_rank_ff, hit_rank_in;
   logic                            empty_fnd_ff, empty_fnd_in;
   logic [lrc_pkg::IDX_W-1:0]       empty_ff, empty_in;
   logic [lrc_pkg::IDX_W-1:0]       oldest_ff, oldest_in;
   logic [lrc_pkg::RANK_W-1:0]      oldest_rank_ff, oldest_rank_in;
   logic [lrc_pkg::KEY_WIDTH-1:0]   oldest_key_ff, oldest_key_in;
   logic [lrc_pkg::IDX_W-1:0]       tgt_ff, tgt_in;
   logic [lrc_pkg::LIMIT_W-1:0]     limit_ff, limit_in;
   logic [lrc_pkg::ENTRIES-1:0]     valid_ff, valid_in;
   logic [lrc_pkg::CNT_W-1:0]       hits_ff, hits_in;
   logic [lrc_pkg::CNT_W-1:0]       misses_ff, misses_in;

   logic                            issue;
   logic                            sweep_done;
   logic [lrc_pkg::KEY_WIDTH-1:0]   rd_key;
   logic [lrc_pkg::RANK_W-1:0]      rd_rank;
   logic                            cur_valid;
   logic                            bump;
   logic                            evict;
   logic [lrc_pkg::CNT_W-1:0]       hits_next;
   logic [lrc_pkg::CNT_W-1:0]       misses_next;

   assign issue      = (state_ff == ST_SCAN || state_ff == ST_UPDATE)
                       && (addr_ff != lrc_pkg::SWEEP_END);
   assign sweep_done = (addr_ff == lrc_pkg::SWEEP_END) && !pipe_vld_ff;
   assign rd_key     = rd_data[lrc_pkg::WORD_W-1:lrc_pkg::RANK_W];
   assign rd_rank    = rd_data[lrc_pkg::RANK_W-1:0];
   assign cur_valid  = valid_ff[pipe_idx_ff];
   assign bump       = cur_valid && ({1'b0, rd_rank} < limit_ff);

   assign rd_en   = issue;
   assign rd_addr = addr_ff[lrc_pkg::IDX_W-1:0];
   assign wr_en   = (state_ff == ST_UPDATE) && pipe_vld_ff;
   assign wr_addr = pipe_idx_ff;
   assign wr_data = (pipe_idx_ff == tgt_ff) ? {key_ff, {lrc_pkg::RANK_W{1'b0}}}
                                            : {rd_key, rd_rank + lrc_pkg::RANK_W'(bump)};

   assign evict       = !hit_ff && !empty_fnd_ff;
   assign hits_next   = (hit_ff && hits_ff != lrc_pkg::CNT_MAX) ? hits_ff + 1'b1 : hits_ff;
   assign misses_next = (!hit_ff && misses_ff != lrc_pkg::CNT_MAX) ? misses_ff + 1'b1
                                                                   : misses_ff;

   assign busy    = (state_ff != ST_IDLE);
   assign res_vld = (state_ff == ST_DONE);
   always_comb begin
      res.hit         = hit_ff;
      res.slot        = tgt_ff;
      res.evicted     = evict;
      res.evicted_key = evict ? oldest_key_ff : '0;
      res.hit_count   = hits_next;
      res.miss_count  = misses_next;
   end

   always_comb begin
      state_in       = state_ff;
      key_in         = key_ff;
      addr_in        = addr_ff;
      pipe_vld_in    = issue;
      pipe_idx_in    = addr_ff[lrc_pkg::IDX_W-1:0];
      hit_in         = hit_ff;
      hit_slot_in    = hit_slot_ff;
      hit_rank_in    = hit_rank_ff;
      empty_fnd_in   = empty_fnd_ff;
      empty_in       = empty_ff;
      oldest_in      = oldest_ff;
      oldest_rank_in = oldest_rank_ff;
      oldest_key_in  = oldest_key_ff;
      tgt_in         = tgt_ff;
      limit_in       = limit_ff;
      valid_in       = valid_ff;
      hits_in        = hits_ff;
      misses_in      = misses_ff;
      if (issue) begin
         addr_in = addr_ff + 1'b1;
      end
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               key_in         = req_key;
               addr_in        = '0;
               hit_in         = 1'b0;
               empty_fnd_in   = 1'b0;
               oldest_in      = '0;
               oldest_rank_in = '0;
               oldest_key_in  = '0;
               state_in       = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (pipe_vld_ff) begin
               if (cur_valid) begin
                  if (!hit_ff && rd_key == key_ff) begin
                     hit_in      = 1'b1;
                     hit_slot_in = pipe_idx_ff;
                     hit_rank_in = rd_rank;
                  end
                  if (rd_rank >= oldest_rank_ff) begin
                     oldest_in      = pipe_idx_ff;
                     oldest_rank_in = rd_rank;
                     oldest_key_in  = rd_key;
                  end
               end else if (!empty_fnd_ff) begin
                  empty_fnd_in = 1'b1;
                  empty_in     = pipe_idx_ff;
               end
            end
            if (sweep_done) begin
               addr_in  = '0;
               state_in = ST_UPDATE;
               if (hit_ff) begin
                  tgt_in   = hit_slot_ff;
                  limit_in = {1'b0, hit_rank_ff};
               end else if (empty_fnd_ff) begin
                  tgt_in   = empty_ff;
                  limit_in = lrc_pkg::LIMIT_ALL;
               end else begin
                  tgt_in   = oldest_ff;
                  limit_in = {1'b0, oldest_rank_ff};
               end
            end
         end
         ST_UPDATE: begin
            if (sweep_done) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (res_take) begin
               valid_in[tgt_ff] = 1'b1;
               hits_in          = hits_next;
               misses_in        = misses_next;
               state_in         = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         pipe_vld_ff <= 1'b0;
         valid_ff    <= '0;
         hits_ff     <= '0;
         misses_ff   <= '0;
      end else begin
         state_ff    <= state_in;
         pipe_vld_ff <= pipe_vld_in;
         valid_ff    <= valid_in;
         hits_ff     <= hits_in;
         misses_ff   <= misses_in;
      end
      key_ff         <= key_in;
      addr_ff        <= addr_in;
      pipe_idx_ff    <= pipe_idx_in;
      hit_ff         <= hit_in;
      hit_slot_ff    <= hit_slot_in;
      hit_rank_ff    <= hit_rank_in;
      empty_fnd_ff   <= empty_fnd_in;
      empty_ff       <= empty_in;
      oldest_ff      <= oldest_in;
      oldest_rank_ff <= oldest_rank_in;
      oldest_key_ff  <= oldest_key_in;
      tgt_ff         <= tgt_in;
      limit_ff       <= limit_in;
   end

   a_pipe_in_sweep: assert property (@(posedge clock) disable iff (reset)
      pipe_vld_ff |-> (state_ff == ST_SCAN || state_ff == ST_UPDATE))
      else $error("memory read data outside a sweep");

   a_hit_slot_valid: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DONE && hit_ff) |-> valid_ff[hit_slot_ff])
      else $error("hit reported on an invalid slot");

   a_evict_only_full: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DONE && evict) |-> (&valid_ff))
      else $error("eviction while an empty slot exists");

   a_valid_grows: assert property (@(posedge clock) disable iff (reset)
      res_take |=> ($countones(valid_ff) >= $past($countones(valid_ff))))
      else $error("valid slot count decreased");

endmodule
